### rtl/core/char_lcd_nibble_sequencer_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the character LCD nibble sequencer.
// Each macro samples on clk and is disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_UNIT_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLNS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLNS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/clns_pkg.sv
// ---------------------------------------------------------------------------
// clns_pkg
// Types, constants and the microcode program of the LCD nibble sequencer.
// ---------------------------------------------------------------------------
package clns_pkg;

  // Request codes.
  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_CURSOR = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_INIT   = 3'd3;
  localparam logic [2:0] OP_SHOW   = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_DATA_WAIT   = 1'b0;
  localparam logic CFG_CURSOR_WAIT = 1'b1;

  localparam logic [15:0] DATA_WAIT_RESET   = 16'd55;
  localparam logic [15:0] CURSOR_WAIT_RESET = 16'd50;
  localparam logic [15:0] CLEAR_WAIT        = 16'd1640;
  localparam logic [13:0] POWER_UP_WAIT     = 14'd15000;
  localparam logic [19:0] TIME_MAX          = 20'd599999;

  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] ROW1_OFFSET   = 8'h40;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;
  localparam logic [7:0] ASCII_COLON   = 8'h3A;

  // Program counter and entry points.
  localparam int PC_W = 6;
  localparam logic [PC_W-1:0] ENTRY_WRITE  = 6'd0;
  localparam logic [PC_W-1:0] ENTRY_CURSOR = 6'd2;
  localparam logic [PC_W-1:0] ENTRY_CLEAR  = 6'd4;
  localparam logic [PC_W-1:0] ENTRY_INIT   = 6'd6;
  localparam logic [PC_W-1:0] ENTRY_SHOW   = 6'd20;

  // Time conversion: five digits by restoring subtraction, the sixth is
  // the final remainder.
  localparam int DIV_DIGITS = 5;
  localparam logic [2:0] LAST_DIV_DIGIT = 3'd4;

  // Character selects for show time.
  localparam logic [2:0] CHAR_REM   = 3'd5;
  localparam logic [2:0] CHAR_COLON = 3'd6;

  typedef enum logic {ACT_EMIT, ACT_DIV} act_t;
  typedef enum logic {SEQ_NEXT, SEQ_LOOP} seq_t;
  typedef enum logic [1:0] {NIB_CONST, NIB_HI, NIB_LO} nib_sel_t;
  typedef enum logic [1:0] {BYTE_INPUT, BYTE_CURSOR, BYTE_CONST, BYTE_CHAR} byte_sel_t;
  typedef enum logic [1:0] {RS_CMD, RS_DATA, RS_INPUT} rs_sel_t;
  typedef enum logic [1:0] {WAIT_INPUT, WAIT_CURSOR, WAIT_DATA, WAIT_CONST} wait_sel_t;

  typedef struct packed {
    act_t        act;
    seq_t        seq;
    nib_sel_t    nib_sel;
    byte_sel_t   byte_sel;
    rs_sel_t     rs_sel;
    wait_sel_t   wait_sel;
    logic [7:0]  konst;
    logic [15:0] wait_k;
    logic        power_up;
    logic [2:0]  char_sel;
    logic        last;
  } ucode_t;

  function automatic ucode_t uw(act_t act, seq_t seq, nib_sel_t n, byte_sel_t b,
                                rs_sel_t r, wait_sel_t w, logic [7:0] k,
                                logic [15:0] wk, logic pu, logic [2:0] ch,
                                logic lst);
    ucode_t u;
    u.act      = act;
    u.seq      = seq;
    u.nib_sel  = n;
    u.byte_sel = b;
    u.rs_sel   = r;
    u.wait_sel = w;
    u.konst    = k;
    u.wait_k   = wk;
    u.power_up = pu;
    u.char_sel = ch;
    u.last     = lst;
    return u;
  endfunction

  // One fixed nibble of the power-up sequence.
  function automatic ucode_t init_w(logic [3:0] nib, logic [15:0] wk, logic pu,
                                    logic lst);
    return uw(ACT_EMIT, SEQ_NEXT, NIB_CONST, BYTE_CONST, RS_CMD, WAIT_CONST,
              {4'h0, nib}, wk, pu, 3'd0, lst);
  endfunction

  // One nibble of a show-time character.
  function automatic ucode_t char_w(nib_sel_t n, logic [2:0] ch, logic lst);
    return uw(ACT_EMIT, SEQ_NEXT, n, BYTE_CHAR, RS_DATA, WAIT_DATA, 8'h00,
              16'd0, 1'b0, ch, lst);
  endfunction

  function automatic ucode_t ucode_rom(logic [PC_W-1:0] addr);
    ucode_t u;
    u = uw(ACT_EMIT, SEQ_NEXT, NIB_CONST, BYTE_CONST, RS_CMD, WAIT_CONST,
           8'h00, 16'd0, 1'b0, 3'd0, 1'b1);
    unique case (addr)
      // Write byte.
      6'd0:  u = uw(ACT_EMIT, SEQ_NEXT, NIB_HI, BYTE_INPUT, RS_INPUT, WAIT_INPUT,
                    8'h00, 16'd0, 1'b0, 3'd0, 1'b0);
      6'd1:  u = uw(ACT_EMIT, SEQ_NEXT, NIB_LO, BYTE_INPUT, RS_INPUT, WAIT_INPUT,
                    8'h00, 16'd0, 1'b0, 3'd0, 1'b1);
      // Move cursor.
      6'd2:  u = uw(ACT_EMIT, SEQ_NEXT, NIB_HI, BYTE_CURSOR, RS_CMD, WAIT_CURSOR,
                    8'h00, 16'd0, 1'b0, 3'd0, 1'b0);
      6'd3:  u = uw(ACT_EMIT, SEQ_NEXT, NIB_LO, BYTE_CURSOR, RS_CMD, WAIT_CURSOR,
                    8'h00, 16'd0, 1'b0, 3'd0, 1'b1);
      // Clear.
      6'd4:  u = uw(ACT_EMIT, SEQ_NEXT, NIB_HI, BYTE_CONST, RS_CMD, WAIT_CONST,
                    CMD_CLEAR, CLEAR_WAIT, 1'b0, 3'd0, 1'b0);
      6'd5:  u = uw(ACT_EMIT, SEQ_NEXT, NIB_LO, BYTE_CONST, RS_CMD, WAIT_CONST,
                    CMD_CLEAR, CLEAR_WAIT, 1'b0, 3'd0, 1'b1);
      // Init.
      6'd6:  u = init_w(4'h3, 16'd4510, 1'b1, 1'b0);
      6'd7:  u = init_w(4'h3, 16'd110,  1'b0, 1'b0);
      6'd8:  u = init_w(4'h3, 16'd40,   1'b0, 1'b0);
      6'd9:  u = init_w(4'h2, 16'd40,   1'b0, 1'b0);
      6'd10: u = init_w(4'h2, 16'd10,   1'b0, 1'b0);
      6'd11: u = init_w(4'h8, 16'd50,   1'b0, 1'b0);
      6'd12: u = init_w(4'h0, 16'd10,   1'b0, 1'b0);
      6'd13: u = init_w(4'h8, 16'd50,   1'b0, 1'b0);
      6'd14: u = init_w(4'h0, 16'd10,   1'b0, 1'b0);
      6'd15: u = init_w(4'h1, 16'd1804, 1'b0, 1'b0);
      6'd16: u = init_w(4'h0, 16'd10,   1'b0, 1'b0);
      6'd17: u = init_w(4'h6, 16'd50,   1'b0, 1'b0);
      6'd18: u = init_w(4'h0, 16'd50,   1'b0, 1'b0);
      6'd19: u = init_w(4'hF, 16'd50,   1'b0, 1'b1);
      // Show time: convert, then cursor to row 1, then mm:ss:nn.
      6'd20: u = uw(ACT_DIV, SEQ_LOOP, NIB_CONST, BYTE_CONST, RS_CMD, WAIT_CONST,
                    8'h00, 16'd0, 1'b0, 3'd0, 1'b0);
      6'd21: u = uw(ACT_EMIT, SEQ_NEXT, NIB_HI, BYTE_CONST, RS_CMD, WAIT_CURSOR,
                    CMD_SET_DDRAM | ROW1_OFFSET, 16'd0, 1'b0, 3'd0, 1'b0);
      6'd22: u = uw(ACT_EMIT, SEQ_NEXT, NIB_LO, BYTE_CONST, RS_CMD, WAIT_CURSOR,
                    CMD_SET_DDRAM | ROW1_OFFSET, 16'd0, 1'b0, 3'd0, 1'b0);
      6'd23: u = char_w(NIB_HI, 3'd0, 1'b0);
      6'd24: u = char_w(NIB_LO, 3'd0, 1'b0);
      6'd25: u = char_w(NIB_HI, 3'd1, 1'b0);
      6'd26: u = char_w(NIB_LO, 3'd1, 1'b0);
      6'd27: u = char_w(NIB_HI, CHAR_COLON, 1'b0);
      6'd28: u = char_w(NIB_LO, CHAR_COLON, 1'b0);
      6'd29: u = char_w(NIB_HI, 3'd2, 1'b0);
      6'd30: u = char_w(NIB_LO, 3'd2, 1'b0);
      6'd31: u = char_w(NIB_HI, 3'd3, 1'b0);
      6'd32: u = char_w(NIB_LO, 3'd3, 1'b0);
      6'd33: u = char_w(NIB_HI, CHAR_COLON, 1'b0);
      6'd34: u = char_w(NIB_LO, CHAR_COLON, 1'b0);
      6'd35: u = char_w(NIB_HI, 3'd4, 1'b0);
      6'd36: u = char_w(NIB_LO, 3'd4, 1'b0);
      6'd37: u = char_w(NIB_HI, CHAR_REM, 1'b0);
      6'd38: u = char_w(NIB_LO, CHAR_REM, 1'b1);
      default: u = uw(ACT_EMIT, SEQ_NEXT, NIB_CONST, BYTE_CONST, RS_CMD, WAIT_CONST,
                      8'h00, 16'd0, 1'b0, 3'd0, 1'b1);
    endcase
    return u;
  endfunction

  // Trial subtrahend: digit weight times 8, 4, 2 or 1.
  function automatic logic [19:0] div_trial(logic [2:0] widx, logic [1:0] bitpos);
    logic [19:0] w;
    unique case (widx)
      3'd0:    w = 20'd60000;
      3'd1:    w = 20'd6000;
      3'd2:    w = 20'd1000;
      3'd3:    w = 20'd100;
      3'd4:    w = 20'd10;
      default: w = 20'd0;
    endcase
    return w << bitpos;
  endfunction

endpackage

### rtl/core/char_lcd_nibble_sequencer_unit.sv
// ---------------------------------------------------------------------------
// char_lcd_nibble_sequencer_unit
// Turns one display request into the nibble transfers of a 4-bit
// character LCD bus, driven by a small microcode program.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_stall   op, data_byte, is_data, wait_units,
//                                            column, row, centiseconds
// transfer  out        out_valid / out_stall nibble, register_select,
//                                            wait_before, wait_after, last
// config    in         cfg_write_enable      cfg_index, cfg_data
//
// One request item is taken per cycle when the unit is idle; the next is
// taken in the cycle after the last transfer of the current one is loaded.
// Write byte, move cursor and clear send two transfers each, init sends 14,
// and show time runs the decimal conversion (four trial subtractions per
// digit in one shared subtractor) and then sends 18 transfers. Each
// transfer stays in the output register until it is taken, for as long as
// out_stall holds it. Synchronous reset returns the unit to idle, clears
// the output valid and loads the register defaults 55 and 50.
//
module char_lcd_nibble_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [7:0]  data_byte,
  input  logic        is_data,
  input  logic [15:0] wait_units,
  input  logic [3:0]  column,
  input  logic        row,
  input  logic [19:0] centiseconds,
  // transfer channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  nibble,
  output logic        register_select,
  output logic [13:0] wait_before,
  output logic [15:0] wait_after,
  output logic        last,
  // configuration port
  input  logic        cfg_write_enable,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

`include "char_lcd_nibble_sequencer_unit_defines.svh"

  // Configuration registers.
  logic [15:0] data_wait;
  logic [15:0] cursor_wait;

  // Sequencer state.
  logic                        busy;
  logic [clns_pkg::PC_W-1:0]   pc;
  clns_pkg::ucode_t            ctl;

  // Operands captured when a request is taken.
  logic [7:0]  req_byte;
  logic        req_rs;
  logic [15:0] req_wait;
  logic [7:0]  req_cursor;

  // Decimal conversion datapath. The remainder left after the last trial
  // is the final centisecond digit.
  logic [19:0] rem;
  logic [2:0]  widx;
  logic [1:0]  bitpos;
  logic [3:0]  dacc;
  logic [3:0]  digits [clns_pkg::DIV_DIGITS];

  logic [19:0] trial;
  logic        take;
  logic [19:0] rem_next;
  logic [3:0]  dacc_next;
  logic        div_step;
  logic        div_done;

  logic                      accept;
  logic                      op_known;
  logic [clns_pkg::PC_W-1:0] entry_pc;
  logic                      out_free;
  logic                      emit;
  logic                      advance;

  logic [7:0]  sel_byte;
  logic [7:0]  char_byte;
  logic [3:0]  nibble_next;
  logic        rs_next;
  logic [15:0] wait_next;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  always_comb begin
    op_known = 1'b1;
    entry_pc = clns_pkg::ENTRY_WRITE;
    unique case (op)
      clns_pkg::OP_WRITE:  entry_pc = clns_pkg::ENTRY_WRITE;
      clns_pkg::OP_CURSOR: entry_pc = clns_pkg::ENTRY_CURSOR;
      clns_pkg::OP_CLEAR:  entry_pc = clns_pkg::ENTRY_CLEAR;
      clns_pkg::OP_INIT:   entry_pc = clns_pkg::ENTRY_INIT;
      clns_pkg::OP_SHOW:   entry_pc = clns_pkg::ENTRY_SHOW;
      default:             op_known = 1'b0;
    endcase
  end

  assign ctl      = clns_pkg::ucode_rom(pc);
  assign out_free = !out_valid || !out_stall;
  assign emit     = busy && (ctl.act == clns_pkg::ACT_EMIT) && out_free;
  assign div_step = busy && (ctl.act == clns_pkg::ACT_DIV);

  // One restoring-division trial per cycle.
  assign trial    = clns_pkg::div_trial(widx, bitpos);
  assign take     = (rem >= trial);
  assign rem_next = take ? (rem - trial) : rem;
  assign div_done = div_step && (bitpos == 2'd0) && (widx == clns_pkg::LAST_DIV_DIGIT);

  always_comb begin
    dacc_next = dacc;
    if (take) begin
      dacc_next[bitpos] = 1'b1;
    end
  end

  // A looping step holds the program counter until the conversion is done.
  assign advance = (ctl.seq == clns_pkg::SEQ_NEXT) || div_done;

  // Transfer datapath, steered by the current control word.
  always_comb begin
    if (ctl.char_sel == clns_pkg::CHAR_COLON) begin
      char_byte = clns_pkg::ASCII_COLON;
    end else if (ctl.char_sel == clns_pkg::CHAR_REM) begin
      char_byte = {clns_pkg::ASCII_DIGIT_HI, rem[3:0]};
    end else begin
      char_byte = {clns_pkg::ASCII_DIGIT_HI, digits[ctl.char_sel]};
    end
  end

  always_comb begin
    unique case (ctl.byte_sel)
      clns_pkg::BYTE_INPUT:  sel_byte = req_byte;
      clns_pkg::BYTE_CURSOR: sel_byte = req_cursor;
      clns_pkg::BYTE_CONST:  sel_byte = ctl.konst;
      clns_pkg::BYTE_CHAR:   sel_byte = char_byte;
      default:               sel_byte = ctl.konst;
    endcase
  end

  always_comb begin
    unique case (ctl.nib_sel)
      clns_pkg::NIB_HI:    nibble_next = sel_byte[7:4];
      clns_pkg::NIB_LO:    nibble_next = sel_byte[3:0];
      default:             nibble_next = ctl.konst[3:0];
    endcase
  end

  always_comb begin
    unique case (ctl.rs_sel)
      clns_pkg::RS_DATA:  rs_next = 1'b1;
      clns_pkg::RS_INPUT: rs_next = req_rs;
      default:            rs_next = 1'b0;
    endcase
  end

  always_comb begin
    unique case (ctl.wait_sel)
      clns_pkg::WAIT_INPUT:  wait_next = req_wait;
      clns_pkg::WAIT_CURSOR: wait_next = cursor_wait;
      clns_pkg::WAIT_DATA:   wait_next = data_wait;
      default:               wait_next = ctl.wait_k;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pc          <= clns_pkg::ENTRY_WRITE;
      out_valid   <= 1'b0;
      data_wait   <= clns_pkg::DATA_WAIT_RESET;
      cursor_wait <= clns_pkg::CURSOR_WAIT_RESET;
    end else begin
      if (cfg_write_enable) begin
        if (cfg_index == clns_pkg::CFG_DATA_WAIT) begin
          data_wait <= cfg_data;
        end else begin
          cursor_wait <= cfg_data;
        end
      end

      // A taken transfer empties the output register unless the next one
      // is loaded in the same cycle.
      if (out_valid && !out_stall && !emit) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        req_byte   <= data_byte;
        req_rs     <= is_data;
        req_wait   <= wait_units;
        req_cursor <= clns_pkg::CMD_SET_DDRAM | {4'h0, column}
                      | (row ? clns_pkg::ROW1_OFFSET : 8'h00);
        rem        <= (centiseconds > clns_pkg::TIME_MAX) ? clns_pkg::TIME_MAX
                                                          : centiseconds;
        widx       <= 3'd0;
        bitpos     <= 2'd3;
        dacc       <= 4'd0;
        if (op_known) begin
          busy <= 1'b1;
          pc   <= entry_pc;
        end
      end

      if (div_step) begin
        rem <= rem_next;
        if (bitpos == 2'd0) begin
          digits[widx] <= dacc_next;
          dacc         <= 4'd0;
          bitpos       <= 2'd3;
          if (!div_done) begin
            widx <= widx + 3'd1;
          end
        end else begin
          dacc   <= dacc_next;
          bitpos <= bitpos - 2'd1;
        end
        if (advance) begin
          pc <= pc + clns_pkg::PC_W'(1);
        end
      end

      if (emit) begin
        out_valid       <= 1'b1;
        nibble          <= nibble_next;
        register_select <= rs_next;
        wait_before     <= ctl.power_up ? clns_pkg::POWER_UP_WAIT : 14'd0;
        wait_after      <= wait_next;
        last            <= ctl.last;
        if (ctl.last) begin
          busy <= 1'b0;
        end else begin
          pc <= pc + clns_pkg::PC_W'(1);
        end
      end
    end
  end

  // Every decimal digit produced by the conversion is at most nine.
  `CLNS_ASSERT_IMP(a_digit_range, div_step && (bitpos == 2'd0), dacc_next <= 4'd9, "conversion digit above nine")

  // Characters are only sent once the remainder is down to one digit.
  `CLNS_ASSERT_IMP(a_rem_final, busy && (ctl.act == clns_pkg::ACT_EMIT) && (ctl.byte_sel == clns_pkg::BYTE_CHAR), rem < 20'd10, "character sent before conversion finished")

  // The final transfer of a request returns the unit to idle.
  `CLNS_ASSERT_NXT(a_last_ends, emit && ctl.last, !busy, "unit still busy after final transfer")

  // A known request starts the program at its entry point.
  `CLNS_ASSERT_NXT(a_start, accept && op_known, busy && (pc == $past(entry_pc)), "request did not start at its entry")

  // A transfer is only loaded while a request is in progress.
  `CLNS_ASSERT_IMP(a_out_from_busy, $rose(out_valid), $past(busy), "transfer without a request")

endmodule

### dv/char_lcd_nibble_sequencer_checker.sv
// ----------------------------------------------------------------------------
// Bus transfer checker for the character LCD nibble sequencer
// Watches the request, transfer and configuration ports, works out the
// nibble transfers each accepted request must cause and compares them in
// order with the transfers the unit hands out.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  op,
  input  logic [7:0]  data_byte,
  input  logic        is_data,
  input  logic [15:0] wait_units,
  input  logic [3:0]  column,
  input  logic        row,
  input  logic [19:0] centiseconds,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  nibble,
  input  logic        register_select,
  input  logic [13:0] wait_before,
  input  logic [15:0] wait_after,
  input  logic        last,
  input  logic        cfg_write_enable,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          transfers_checked
);

  localparam logic SEL_COMMAND   = 1'b0;
  localparam logic SEL_CHARACTER = 1'b1;
  localparam int unsigned CS_PER_MINUTE = 6000;
  localparam int unsigned CS_PER_SECOND = 100;
  localparam logic [7:0] ASCII_ZERO = {clns_pkg::ASCII_DIGIT_HI, 4'h0};

  // Power-up sequence: nibbles and the wait after each one.
  localparam logic [0:13][3:0] INIT_NIBBLES = {
    4'h3, 4'h3, 4'h3, 4'h2, 4'h2, 4'h8, 4'h0,
    4'h8, 4'h0, 4'h1, 4'h0, 4'h6, 4'h0, 4'hF
  };
  localparam logic [0:13][15:0] INIT_WAITS = {
    16'd4510, 16'd110, 16'd40, 16'd40, 16'd10, 16'd50, 16'd10,
    16'd50, 16'd10, 16'd1804, 16'd10, 16'd50, 16'd50, 16'd50
  };

  typedef struct {
    logic [3:0]  nibble;
    logic        rs;
    logic [13:0] wait_before;
    logic [15:0] wait_after;
    logic        last;
  } bus_xfer_t;

  bus_xfer_t   pending_transfers[$];
  logic [15:0] data_wait_q;
  logic [15:0] cursor_wait_q;

  function automatic void queue_nibble(logic [3:0] nib, logic rs, logic [13:0] wait_pre,
                                       logic [15:0] after, logic final_one);
    bus_xfer_t x;
    x.nibble      = nib;
    x.rs          = rs;
    x.wait_before = wait_pre;
    x.wait_after  = after;
    x.last        = final_one;
    pending_transfers.push_back(x);
  endfunction

  // A byte always goes out upper nibble first.
  function automatic void queue_byte(logic [7:0] value, logic rs, logic [15:0] after,
                                     logic final_one);
    queue_nibble(value[7:4], rs, 14'd0, after, 1'b0);
    queue_nibble(value[3:0], rs, 14'd0, after, final_one);
  endfunction

  function automatic void predict_transfers(logic [2:0] code, logic [7:0] value, logic rs,
                                            logic [15:0] units, logic [3:0] col,
                                            logic cursor_row, logic [19:0] cs);
    int unsigned t;
    int unsigned minutes;
    int unsigned seconds;
    int unsigned hundredths;
    logic [7:0]  text [8];
    int i;
    case (code)
      clns_pkg::OP_WRITE:  queue_byte(value, rs, units, 1'b1);
      clns_pkg::OP_CURSOR: queue_byte(clns_pkg::CMD_SET_DDRAM | {4'h0, col}
                                      | (cursor_row ? clns_pkg::ROW1_OFFSET : 8'h00),
                                      SEL_COMMAND, cursor_wait_q, 1'b1);
      clns_pkg::OP_CLEAR:  queue_byte(clns_pkg::CMD_CLEAR, SEL_COMMAND,
                                      clns_pkg::CLEAR_WAIT, 1'b1);
      clns_pkg::OP_INIT: begin
        for (i = 0; i < 14; i++)
          queue_nibble(INIT_NIBBLES[i], SEL_COMMAND,
                       (i == 0) ? clns_pkg::POWER_UP_WAIT : 14'd0,
                       INIT_WAITS[i], i == 13);
      end
      clns_pkg::OP_SHOW: begin
        t = 32'((cs > clns_pkg::TIME_MAX) ? clns_pkg::TIME_MAX : cs);
        minutes    = t / CS_PER_MINUTE;
        seconds    = (t % CS_PER_MINUTE) / CS_PER_SECOND;
        hundredths = t % CS_PER_SECOND;
        text[0] = 8'(ASCII_ZERO + minutes / 10);
        text[1] = 8'(ASCII_ZERO + minutes % 10);
        text[2] = clns_pkg::ASCII_COLON;
        text[3] = 8'(ASCII_ZERO + seconds / 10);
        text[4] = 8'(ASCII_ZERO + seconds % 10);
        text[5] = clns_pkg::ASCII_COLON;
        text[6] = 8'(ASCII_ZERO + hundredths / 10);
        text[7] = 8'(ASCII_ZERO + hundredths % 10);
        queue_byte(clns_pkg::CMD_SET_DDRAM | clns_pkg::ROW1_OFFSET, SEL_COMMAND,
                   cursor_wait_q, 1'b0);
        for (i = 0; i < 8; i++)
          queue_byte(text[i], SEL_CHARACTER, data_wait_q, i == 7);
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    bus_xfer_t want;
    if (rst) begin
      data_wait_q       = clns_pkg::DATA_WAIT_RESET;
      cursor_wait_q     = clns_pkg::CURSOR_WAIT_RESET;
      mismatches        = 0;
      transfers_checked = 0;
      pending_transfers.delete();
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          clns_pkg::CFG_DATA_WAIT:   data_wait_q = cfg_data;
          clns_pkg::CFG_CURSOR_WAIT: cursor_wait_q = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_transfers.size() == 0) begin
          $error("transfer with nibble %0h arrived with none expected", nibble);
          mismatches++;
        end else begin
          want = pending_transfers.pop_front();
          check_field("nibble", 16'(want.nibble), 16'(nibble));
          check_field("register_select", 16'(want.rs), 16'(register_select));
          check_field("wait_before", 16'(want.wait_before), 16'(wait_before));
          check_field("wait_after", want.wait_after, wait_after);
          check_field("last", 16'(want.last), 16'(last));
          transfers_checked++;
        end
      end
      if (in_valid && !in_stall)
        predict_transfers(op, data_byte, is_data, wait_units, column, row, centiseconds);
    end
    outstanding = pending_transfers.size();
  end

endmodule

### dv/tb_char_lcd_nibble_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the character LCD nibble sequencer unit
// Feeds display requests of every kind through the unit under several wait
// register settings, with random idling on both channels and one long
// output hold-off, and lets the bus transfer checker compare every transfer.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_sequencer_unit;

  // Op codes the unit ignores.
  localparam logic [2:0] OP_RESERVED_LO = 3'd5;
  localparam logic [2:0] OP_RESERVED_HI = 3'd7;

  // Cycles to let pass once the last transfer is in. Show time is the
  // longest request, so this also covers an ignored op that might still
  // be in flight.
  localparam int DRAIN_CYCLES = 60;
  // Length of the output hold-off that fills the unit up.
  localparam int HOLD_CYCLES  = 400;
  // Hard stop: far beyond the slowest legal run.
  localparam int RUN_LIMIT    = 2_000_000;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  data_byte;
    logic        is_data;
    logic [15:0] wait_units;
    logic [3:0]  column;
    logic        row;
    logic [19:0] centiseconds;
  } lcd_request_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  op;
  logic [7:0]  data_byte;
  logic        is_data;
  logic [15:0] wait_units;
  logic [3:0]  column;
  logic        row;
  logic [19:0] centiseconds;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  nibble;
  logic        register_select;
  logic [13:0] wait_before;
  logic [15:0] wait_after;
  logic        last;
  logic        cfg_write_enable;
  logic        cfg_index;
  logic [15:0] cfg_data;

  int mismatches;
  int outstanding;
  int transfers_checked;

  // When calm is set neither side idles. hold_request asks the receiver for
  // one long hold-off; the receiver clears it when the hold-off is over.
  bit calm;
  bit hold_request;

  int requests_sent;
  int ignored_sent;
  int show_sent;
  int saturated_sent;
  int settings_used;

  char_lcd_nibble_sequencer_unit dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .data_byte        (data_byte),
    .is_data          (is_data),
    .wait_units       (wait_units),
    .column           (column),
    .row              (row),
    .centiseconds     (centiseconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .nibble           (nibble),
    .register_select  (register_select),
    .wait_before      (wait_before),
    .wait_after       (wait_after),
    .last             (last),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  char_lcd_nibble_sequencer_checker bus_check (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .op                (op),
    .data_byte         (data_byte),
    .is_data           (is_data),
    .wait_units        (wait_units),
    .column            (column),
    .row               (row),
    .centiseconds      (centiseconds),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .nibble            (nibble),
    .register_select   (register_select),
    .wait_before       (wait_before),
    .wait_after        (wait_after),
    .last              (last),
    .cfg_write_enable  (cfg_write_enable),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .transfers_checked (transfers_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic lcd_request_t make_request(logic [2:0] code, logic [7:0] value,
                                                logic rs, logic [15:0] units,
                                                logic [3:0] col, logic cursor_row,
                                                logic [19:0] cs);
    lcd_request_t r;
    r.op           = code;
    r.data_byte    = value;
    r.is_data      = rs;
    r.wait_units   = units;
    r.column       = col;
    r.row          = cursor_row;
    r.centiseconds = cs;
    return r;
  endfunction

  // A random request. All fields are filled whatever the op, so that the
  // unused ones toggle as well. Write byte is the most common request; show
  // time gets a good share since it is the deepest path through the unit.
  function automatic lcd_request_t random_request();
    lcd_request_t r;
    int unsigned  pick;
    r.data_byte    = 8'($urandom);
    r.is_data      = 1'($urandom);
    r.wait_units   = 16'($urandom);
    r.column       = 4'($urandom);
    r.row          = 1'($urandom);
    r.centiseconds = 20'($urandom_range(clns_pkg::TIME_MAX));
    pick = $urandom_range(99);
    if (pick < 35)
      r.op = clns_pkg::OP_WRITE;
    else if (pick < 55)
      r.op = clns_pkg::OP_CURSOR;
    else if (pick < 65)
      r.op = clns_pkg::OP_CLEAR;
    else if (pick < 72)
      r.op = clns_pkg::OP_INIT;
    else if (pick < 95)
      r.op = clns_pkg::OP_SHOW;
    else
      r.op = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
    // Bias the wait toward its extremes now and then.
    case ($urandom_range(9))
      0: r.wait_units = 16'h0000;
      1: r.wait_units = 16'hFFFF;
      default: ;
    endcase
    // Times just below and above the limit, and the whole 20-bit range.
    case ($urandom_range(9))
      0: r.centiseconds = 20'($urandom);
      1: r.centiseconds = clns_pkg::TIME_MAX - 20'($urandom_range(200));
      2: r.centiseconds = clns_pkg::TIME_MAX + 20'($urandom_range(1, 200));
      default: ;
    endcase
    return r;
  endfunction

  // Drives one request at a falling edge and holds it until the unit takes
  // it; returns at the falling edge after the accepting rising edge.
  task automatic send_request(input lcd_request_t r);
    op           <= r.op;
    data_byte    <= r.data_byte;
    is_data      <= r.is_data;
    wait_units   <= r.wait_units;
    column       <= r.column;
    row          <= r.row;
    centiseconds <= r.centiseconds;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    @(negedge clk);
  endtask

  // The sender goes quiet in about 9 of 100 items.
  task automatic rest_sender();
    if (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6))
        @(negedge clk);
    end
  endtask

  task automatic offer(input lcd_request_t r);
    rest_sender();
    send_request(r);
    requests_sent++;
    if (r.op > clns_pkg::OP_SHOW)
      ignored_sent++;
    if (r.op == clns_pkg::OP_SHOW)
      show_sent++;
    if (r.op == clns_pkg::OP_SHOW && r.centiseconds > clns_pkg::TIME_MAX)
      saturated_sent++;
  endtask

  // Random requests until n of them are ones the unit acts on.
  task automatic run_random(input int n);
    lcd_request_t r;
    int taken;
    taken = 0;
    while (taken < n) begin
      r = random_request();
      if (r.op <= clns_pkg::OP_SHOW)
        taken++;
      offer(r);
    end
  endtask

  // Stops offering, waits for every expected transfer and then lets the unit
  // run dry, so that the wait registers can be written safely.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (outstanding != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES)
      @(negedge clk);
  endtask

  task automatic write_register(input logic index, input logic [15:0] value);
    cfg_index        <= index;
    cfg_data         <= value;
    cfg_write_enable <= 1'b1;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver: stalls at random with a chance of about 9 in 100, never while calm is set, and
  // once holds the output off for a long stretch on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES)
          @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 9);
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [15:0] data_wait_set;
    logic [15:0] cursor_wait_set;
    rst              = 1'b1;
    in_valid         = 1'b0;
    op               = clns_pkg::OP_WRITE;
    data_byte        = 8'h00;
    is_data          = 1'b0;
    wait_units       = 16'h0000;
    column           = 4'h0;
    row              = 1'b0;
    centiseconds     = 20'd0;
    out_stall        = 1'b0;
    cfg_write_enable = 1'b0;
    cfg_index        = clns_pkg::CFG_DATA_WAIT;
    cfg_data         = 16'h0000;
    calm             = 1'b0;
    hold_request     = 1'b0;
    requests_sent    = 0;
    ignored_sent     = 0;
    show_sent        = 0;
    saturated_sent   = 0;
    settings_used    = 1;

    repeat (2)
      @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests under the reset wait values. Write byte at the
    // extremes of byte, register select and wait.
    offer(make_request(clns_pkg::OP_WRITE, 8'h00, 1'b0, 16'h0000, 4'h0, 1'b0, 20'd0));
    offer(make_request(clns_pkg::OP_WRITE, 8'hFF, 1'b1, 16'hFFFF, 4'hF, 1'b1, 20'hFFFFF));
    offer(make_request(clns_pkg::OP_WRITE, 8'h5A, 1'b1, 16'hA55A, 4'h5, 1'b0, 20'h5A5A5));
    // Cursor moves to both rows and the first and last columns.
    offer(make_request(clns_pkg::OP_CURSOR, 8'h00, 1'b0, 16'h0000, 4'h0, 1'b0, 20'd0));
    offer(make_request(clns_pkg::OP_CURSOR, 8'h00, 1'b0, 16'h0000, 4'hF, 1'b1, 20'd0));
    offer(make_request(clns_pkg::OP_CURSOR, 8'h00, 1'b1, 16'h0000, 4'h9, 1'b0, 20'd0));
    offer(make_request(clns_pkg::OP_CURSOR, 8'h00, 1'b0, 16'h0000, 4'h6, 1'b1, 20'd0));
    offer(make_request(clns_pkg::OP_CLEAR, 8'h00, 1'b0, 16'h0000, 4'h0, 1'b0, 20'd0));
    offer(make_request(clns_pkg::OP_INIT, 8'h00, 1'b0, 16'h0000, 4'h0, 1'b0, 20'd0));
    // Show time at zero, at the limit, just past it, at the top of the
    // field, and at the minute and hour-like rollovers.
    offer(make_request(clns_pkg::OP_SHOW, 8'h00, 1'b0, 16'h0000, 4'h0, 1'b0, 20'd0));
    offer(make_request(clns_pkg::OP_SHOW, 8'h00, 1'b0, 16'h0000, 4'h0, 1'b0,
                       clns_pkg::TIME_MAX));
    offer(make_request(clns_pkg::OP_SHOW, 8'h00, 1'b0, 16'h0000, 4'h0, 1'b0,
                       clns_pkg::TIME_MAX + 20'd1));
    offer(make_request(clns_pkg::OP_SHOW, 8'h00, 1'b0, 16'h0000, 4'h0, 1'b0, 20'hFFFFF));
    offer(make_request(clns_pkg::OP_SHOW, 8'h00, 1'b0, 16'h0000, 4'h0, 1'b0, 20'd5999));
    offer(make_request(clns_pkg::OP_SHOW, 8'h00, 1'b0, 16'h0000, 4'h0, 1'b0, 20'd6000));
    offer(make_request(clns_pkg::OP_SHOW, 8'h00, 1'b0, 16'h0000, 4'h0, 1'b0, 20'd359999));
    offer(make_request(clns_pkg::OP_SHOW, 8'h00, 1'b0, 16'h0000, 4'h0, 1'b0, 20'd123456));
    // Ops the unit must ignore, with a real request after each.
    for (int code = OP_RESERVED_LO; code <= OP_RESERVED_HI; code++) begin
      offer(make_request(3'(code), 8'hC3, 1'b1, 16'h1234, 4'hA, 1'b1, 20'd4242));
      offer(make_request(clns_pkg::OP_CLEAR, 8'h00, 1'b0, 16'h0000, 4'h0, 1'b0, 20'd0));
    end
    finish_phase();

    // Random phases, each under its own pair of wait values: both extremes
    // crossed, then random values, then the reset values again.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          data_wait_set   = 16'h0000;
          cursor_wait_set = 16'hFFFF;
        end
        1: begin
          data_wait_set   = 16'hFFFF;
          cursor_wait_set = 16'h0000;
        end
        2, 3: begin
          data_wait_set   = 16'($urandom);
          cursor_wait_set = 16'($urandom);
        end
        default: begin
          data_wait_set   = clns_pkg::DATA_WAIT_RESET;
          cursor_wait_set = clns_pkg::CURSOR_WAIT_RESET;
        end
      endcase
      write_register(clns_pkg::CFG_DATA_WAIT, data_wait_set);
      write_register(clns_pkg::CFG_CURSOR_WAIT, cursor_wait_set);
      settings_used++;
      // The second phase runs with no idling on either side.
      calm = (phase == 1);
      if (phase == 2) begin
        // The receiver holds off while show-time requests keep coming, so
        // the unit fills and has to stall its input.
        hold_request = 1'b1;
        repeat (16)
          offer(make_request(clns_pkg::OP_SHOW, 8'($urandom), 1'($urandom),
                             16'($urandom), 4'($urandom), 1'($urandom),
                             20'($urandom_range(clns_pkg::TIME_MAX))));
      end
      run_random((phase == 2) ? 35 : 50);
      finish_phase();
    end
    calm = 1'b0;

    $display("Sent %0d requests (%0d ignored ops, %0d show time, %0d past the time limit)",
             requests_sent, ignored_sent, show_sent, saturated_sent);
    $display("under %0d wait settings; %0d bus transfers checked, %0d mismatches.",
             settings_used, transfers_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
